/* src/descriptor_table_engine_assert.svh */
// Assertion macros shared by the descriptor table checks
`ifndef DESCRIPTOR_TABLE_ENGINE_ASSERT_SVH
`define DESCRIPTOR_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication under reset
`define DTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("descriptor table check failed");

// Next-cycle implication under reset
`define DTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("descriptor table check failed");

`endif

/* src/dte_pkg.sv */
// Types, codes and helpers shared by the descriptor table engine
package dte_pkg;

    localparam int DEF_TABLE_SIZE = 64;
    localparam int HANDLE_BITS    = 16;
    localparam int RIGHTS_BITS    = 4;
    localparam int RIGHT_DUP_BIT  = 3;

    typedef enum logic [3:0] {
        REQ_ALLOC      = 4'd0,
        REQ_GET        = 4'd1,
        REQ_READ       = 4'd2,
        REQ_LIMIT      = 4'd3,
        REQ_CLOSE      = 4'd4,
        REQ_DUP        = 4'd5,
        REQ_DUP_TO     = 4'd6,
        REQ_DUP_MIN    = 4'd7,
        REQ_SWEEP_CX   = 4'd8,
        REQ_CLOSE_ALL  = 4'd9
    } req_code_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_INVALID  = 3'd1,
        STATUS_BAD_SLOT = 3'd2,
        STATUS_DENIED   = 3'd3,
        STATUS_NO_PERM  = 3'd4,
        STATUS_FULL     = 3'd5
    } status_t;

    typedef struct packed {
        req_code_t              req_type;
        logic [HANDLE_BITS-1:0] object_handle;
        logic [1:0]             access_mode;
        logic [7:0]             rights_arg;
        logic [7:0]             slot_index;
        logic [7:0]             target_slot;
        logic                   close_on_exec;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [7:0]             slot_out;
        logic [HANDLE_BITS-1:0] handle_out;
        logic [RIGHTS_BITS-1:0] rights_out;
        logic                   acquire_ref;
        logic                   release_ref;
        logic                   last;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT2,
        S_SWEEP_FIND,
        S_SWEEP_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit2;
        logic sweep_find;
        logic sweep_emit;
    } dte_cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_sweep;
        logic second;
        logic found;
        logic more;
    } dte_stat_t;

    function automatic logic [RIGHTS_BITS-1:0] default_rights(input logic [1:0] mode);
        logic [RIGHTS_BITS-1:0] r;
        r    = 4'b1100;
        r[0] = (mode != 2'd1);
        r[1] = (mode != 2'd0);
        return r;
    endfunction

    function automatic rsp_t make_fail(input status_t st);
        rsp_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic rsp_t make_ok(input logic [7:0] slot,
                                     input logic [HANDLE_BITS-1:0] handle,
                                     input logic [RIGHTS_BITS-1:0] rights,
                                     input logic acq, input logic rel,
                                     input logic last);
        rsp_t r;
        r.status      = STATUS_OK;
        r.slot_out    = slot;
        r.handle_out  = handle;
        r.rights_out  = rights;
        r.acquire_ref = acq;
        r.release_ref = rel;
        r.last        = last;
        return r;
    endfunction

endpackage

/* src/dte_ctrl.sv */
// Request sequencer for the descriptor table engine
module dte_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  dte_pkg::dte_stat_t stat,
    output dte_pkg::dte_cmd_t  cmd
);
    import dte_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_sweep)
                begin
                    state_next = S_SWEEP_FIND;
                end
                else if (stat.out_free)
                begin
                    state_next = stat.second ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWEEP_FIND:
            begin
                state_next = stat.found ? S_SWEEP_OUT : S_IDLE;
            end
            S_SWEEP_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.more ? S_SWEEP_FIND : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_EXEC:
            begin
                cmd.exec = !stat.is_sweep && stat.out_free;
            end
            S_EMIT2:
            begin
                cmd.emit2 = stat.out_free;
            end
            S_SWEEP_FIND:
            begin
                cmd.sweep_find = 1'b1;
            end
            S_SWEEP_OUT:
            begin
                cmd.sweep_emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* src/dte_datapath.sv */
// Slot table, free-slot search, request decode and result register
module dte_datapath #(
    parameter int TABLE_SIZE = dte_pkg::DEF_TABLE_SIZE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dte_pkg::req_t      req,
    input  dte_pkg::dte_cmd_t  cmd,
    output dte_pkg::dte_stat_t stat,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output dte_pkg::rsp_t      rsp
);
    import dte_pkg::*;

    localparam int IDXW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [RIGHTS_BITS-1:0] rights;
    } entry_t;

    function automatic logic [IDXW-1:0] lowest_set(input logic [TABLE_SIZE-1:0] v);
        logic [IDXW-1:0] idx;
        idx = '0;
        for (int i = TABLE_SIZE - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IDXW'(i);
            end
        end
        return idx;
    endfunction

    entry_t                 mem [TABLE_SIZE];
    entry_t                 rda_reg;
    entry_t                 rdb_reg;
    req_t                   rq_reg;
    logic [TABLE_SIZE-1:0]  used_reg, used_next;
    logic [TABLE_SIZE-1:0]  cloexec_reg;
    rsp_t                   out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic [IDXW-1:0]        sweep_idx_reg;
    logic                   sweep_more_reg;

    logic [TABLE_SIZE-1:0]  free_mask;
    logic [TABLE_SIZE-1:0]  sweep_mask;
    logic [7:0]             search_start;
    logic                   free_found;
    logic [IDXW-1:0]        free_idx;
    logic                   sweep_found;
    logic [IDXW-1:0]        sweep_idx;
    logic                   sweep_more;

    logic [IDXW-1:0]        src_idx;
    logic [IDXW-1:0]        tgt_idx;
    logic                   src_in;
    logic                   tgt_in;
    logic                   src_used;
    logic                   rarg_bad;
    logic [RIGHTS_BITS-1:0] def_rights;
    logic [RIGHTS_BITS-1:0] grant_rights;
    logic [RIGHTS_BITS-1:0] rarg_lo;

    rsp_t                   res;
    logic                   wr_en;
    logic [IDXW-1:0]        wr_idx;
    entry_t                 wr_data;
    logic                   set_en;
    logic                   clr_en;
    logic [IDXW-1:0]        fill_idx;
    logic                   fill_cx;
    logic                   second;

    assign src_idx    = rq_reg.slot_index[IDXW-1:0];
    assign tgt_idx    = rq_reg.target_slot[IDXW-1:0];
    assign src_in     = 32'(rq_reg.slot_index) < 32'(TABLE_SIZE);
    assign tgt_in     = 32'(rq_reg.target_slot) < 32'(TABLE_SIZE);
    assign src_used   = src_in && used_reg[src_idx];
    assign rarg_bad   = rq_reg.rights_arg[7:RIGHTS_BITS] != '0;
    assign rarg_lo    = rq_reg.rights_arg[RIGHTS_BITS-1:0];
    assign def_rights = default_rights(rq_reg.access_mode);
    assign search_start = (rq_reg.req_type == REQ_DUP_MIN) ? rq_reg.target_slot : 8'd0;

    always_comb
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            free_mask[i]  = !used_reg[i] && (32'(i) >= 32'(search_start));
            sweep_mask[i] = used_reg[i]
                            && (cloexec_reg[i] || rq_reg.req_type == REQ_CLOSE_ALL);
        end
    end

    assign free_found  = |free_mask;
    assign free_idx    = lowest_set(free_mask);
    assign sweep_found = |sweep_mask;
    assign sweep_idx   = lowest_set(sweep_mask);
    assign sweep_more  = |(sweep_mask & ~(TABLE_SIZE'(1) << sweep_idx));

    always_comb
    begin
        res          = make_fail(STATUS_INVALID);
        wr_en        = 1'b0;
        wr_idx       = src_idx;
        wr_data      = rda_reg;
        set_en       = 1'b0;
        clr_en       = 1'b0;
        fill_idx     = free_idx;
        fill_cx      = 1'b0;
        second       = 1'b0;
        grant_rights = rda_reg.rights & rarg_lo;
        unique case (rq_reg.req_type)
            REQ_ALLOC:
            begin
                grant_rights = (rarg_lo == '0) ? def_rights : (rarg_lo & def_rights);
                priority if (rq_reg.rights_arg != 8'd0 && rarg_bad)
                    res = make_fail(STATUS_INVALID);
                else if (grant_rights == '0)
                    res = make_fail(STATUS_DENIED);
                else if (!free_found)
                    res = make_fail(STATUS_FULL);
                else
                begin
                    res = make_ok(8'(free_idx), rq_reg.object_handle, grant_rights,
                                  1'b0, 1'b0, 1'b1);
                    wr_en   = 1'b1;
                    wr_idx  = free_idx;
                    wr_data = '{handle: rq_reg.object_handle, rights: grant_rights};
                    set_en  = 1'b1;
                    fill_cx = rq_reg.close_on_exec;
                end
            end
            REQ_GET:
            begin
                priority if (!src_in)
                    res = make_fail(STATUS_BAD_SLOT);
                else if (rarg_bad)
                    res = make_fail(STATUS_INVALID);
                else if (!src_used || (rda_reg.rights & rarg_lo) != rarg_lo)
                    res = make_fail(STATUS_BAD_SLOT);
                else
                    res = make_ok(rq_reg.slot_index, rda_reg.handle, rda_reg.rights,
                                  1'b1, 1'b0, 1'b1);
            end
            REQ_READ:
            begin
                if (!src_used)
                    res = make_fail(STATUS_BAD_SLOT);
                else
                    res = make_ok(rq_reg.slot_index, rda_reg.handle, rda_reg.rights,
                                  1'b0, 1'b0, 1'b1);
            end
            REQ_LIMIT:
            begin
                priority if (!src_in)
                    res = make_fail(STATUS_BAD_SLOT);
                else if (rarg_bad)
                    res = make_fail(STATUS_INVALID);
                else if (!src_used)
                    res = make_fail(STATUS_BAD_SLOT);
                else
                begin
                    res = make_ok(rq_reg.slot_index, rda_reg.handle, grant_rights,
                                  1'b0, 1'b0, 1'b1);
                    wr_en   = 1'b1;
                    wr_data = '{handle: rda_reg.handle, rights: grant_rights};
                end
            end
            REQ_CLOSE:
            begin
                if (!src_used)
                    res = make_fail(STATUS_BAD_SLOT);
                else
                begin
                    res = make_ok(rq_reg.slot_index, rda_reg.handle, '0,
                                  1'b0, 1'b1, 1'b1);
                    clr_en = 1'b1;
                end
            end
            REQ_DUP, REQ_DUP_MIN:
            begin
                priority if (rq_reg.req_type == REQ_DUP_MIN && !tgt_in)
                    res = make_fail(STATUS_FULL);
                else if (!src_used)
                    res = make_fail(STATUS_BAD_SLOT);
                else if (!rda_reg.rights[RIGHT_DUP_BIT])
                    res = make_fail(STATUS_NO_PERM);
                else if (!free_found)
                    res = make_fail(STATUS_FULL);
                else
                begin
                    res = make_ok(8'(free_idx), rda_reg.handle, rda_reg.rights,
                                  1'b1, 1'b0, 1'b1);
                    wr_en   = 1'b1;
                    wr_idx  = free_idx;
                    set_en  = 1'b1;
                    fill_cx = (rq_reg.req_type == REQ_DUP_MIN) && rq_reg.close_on_exec;
                end
            end
            REQ_DUP_TO:
            begin
                priority if (!tgt_in || !src_used)
                    res = make_fail(STATUS_BAD_SLOT);
                else if (rq_reg.slot_index == rq_reg.target_slot)
                    res = make_ok(rq_reg.target_slot, rda_reg.handle, rda_reg.rights,
                                  1'b0, 1'b0, 1'b1);
                else if (!rda_reg.rights[RIGHT_DUP_BIT])
                    res = make_fail(STATUS_NO_PERM);
                else
                begin
                    second = used_reg[tgt_idx];
                    res = make_ok(rq_reg.target_slot, rda_reg.handle, rda_reg.rights,
                                  1'b1, 1'b0, !second);
                    wr_en    = 1'b1;
                    wr_idx   = tgt_idx;
                    set_en   = 1'b1;
                    fill_idx = tgt_idx;
                    fill_cx  = rq_reg.close_on_exec;
                end
            end
            REQ_SWEEP_CX, REQ_CLOSE_ALL:
            begin
                res = make_fail(STATUS_OK);
            end
            default:
            begin
                res = make_fail(STATUS_INVALID);
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.exec && set_en)
        begin
            used_next[fill_idx] = 1'b1;
        end
        if (cmd.exec && clr_en)
        begin
            used_next[src_idx] = 1'b0;
        end
        if (cmd.sweep_find && sweep_found)
        begin
            used_next[sweep_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && set_en)
        begin
            cloexec_reg[fill_idx] <= fill_cx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rda_reg <= mem[req.slot_index[IDXW-1:0]];
            rdb_reg <= mem[req.target_slot[IDXW-1:0]];
        end
        else if (cmd.sweep_find)
        begin
            rda_reg <= mem[sweep_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rq_reg <= req;
        end
        if (cmd.sweep_find)
        begin
            sweep_idx_reg  <= sweep_idx;
            sweep_more_reg <= sweep_more;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        priority if (cmd.exec)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (cmd.emit2)
        begin
            out_next       = make_ok(rq_reg.target_slot, rdb_reg.handle, rda_reg.rights,
                                     1'b0, 1'b1, 1'b1);
            out_valid_next = 1'b1;
        end
        else if (cmd.sweep_emit)
        begin
            out_next       = make_ok(8'(sweep_idx_reg), rda_reg.handle, '0,
                                     1'b0, 1'b1, !sweep_more_reg);
            out_valid_next = 1'b1;
        end
        else
        begin
            out_next = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid     = out_valid_reg;
    assign rsp           = out_reg;

    assign stat.out_free = !out_valid_reg || rsp_ready;
    assign stat.is_sweep = rq_reg.req_type == REQ_SWEEP_CX
                           || rq_reg.req_type == REQ_CLOSE_ALL;
    assign stat.second   = second;
    assign stat.found    = sweep_found;
    assign stat.more     = sweep_more_reg;

endmodule

/* src/descriptor_table_engine.sv */
// Descriptor table engine top level
//
// A table of TABLE_SIZE slots holding an object handle, four rights bits and a
// close-on-exec mark, with a valid bit per slot cleared at reset. A request is
// taken in the idle state, which also reads the source and target entries
// from the two registered read ports of the table RAM, and completes in the
// exec state, where the lowest-free search (one priority encoder over the
// valid bits) and the table update are done once the result register is free.
// A new request is taken only back in idle. A dup-to displacing a used slot
// gives a second item, the old handle, from the emit2 state. A sweep then
// alternates find (which reads the freed slot from the RAM) and emit for each
// freed slot. Results carry last on the final item of each request; a sweep
// that frees nothing gives no item.
module descriptor_table_engine #(
    parameter int TABLE_SIZE = dte_pkg::DEF_TABLE_SIZE
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dte_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dte_pkg::rsp_t rsp
);
    import dte_pkg::*;

    dte_cmd_t  cmd;
    dte_stat_t stat;

    dte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dte_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* src/dte_checker.sv */
// Port-level checks for the descriptor table engine, bound to the top level
`include "descriptor_table_engine_assert.svh"

module dte_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input dte_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input dte_pkg::rsp_t rsp
);
    import dte_pkg::*;

    `DTE_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    `DTE_ASSERT_IMP(a_err_clean, clk, rst_n, rsp_valid && rsp.status != STATUS_OK, rsp.last && rsp.slot_out == 8'd0 && rsp.handle_out == '0 && rsp.rights_out == '0 && !rsp.acquire_ref && !rsp.release_ref)

    `DTE_ASSERT_IMP(a_ref_excl, clk, rst_n, rsp_valid, !(rsp.acquire_ref && rsp.release_ref))

    `DTE_ASSERT_IMP(a_no_take_midreq, clk, rst_n, rsp_valid && rsp_ready && !rsp.last, !req_ready)

endmodule

bind descriptor_table_engine dte_checker u_dte_checker (.*);

/* test/descriptor_table_engine_tb.sv */
// Self-checking testbench for the descriptor table engine: directed table, then random traffic
module descriptor_table_engine_tb;
    import dte_pkg::*;

    localparam int SLOTS = DEF_TABLE_SIZE;
    localparam logic [3:0] REQ_UNKNOWN = 4'd15;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 28;
    localparam int KIND_FILL = 0;
    localparam int KIND_MIXED = 1;
    localparam int KIND_DRAIN = 2;

    typedef struct {
        req_t item;
        bit   typed;
        rsp_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    logic rsp_valid;
    logic rsp_ready;
    req_t req_bus;
    rsp_t rsp_bus;

    bit                     tbl_used [SLOTS];
    logic [HANDLE_BITS-1:0] tbl_handle [SLOTS];
    logic [3:0]             tbl_rights [SLOTS];
    bit                     tbl_cloexec [SLOTS];

    rsp_t      due_results [$];
    stim_row_t rows [$];
    int        mismatches = 0;
    bit        idle_on = 1'b1;

    descriptor_table_engine #(
        .TABLE_SIZE(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req_bus),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rsp_t status_only(input status_t st);
        return '{st, 8'd0, {HANDLE_BITS{1'b0}}, 4'd0, 1'b0, 1'b0, 1'b1};
    endfunction

    function automatic rsp_t ok_rsp(input logic [7:0] slot, input logic [HANDLE_BITS-1:0] h,
                                    input logic [3:0] rts, input logic acq, input logic rel,
                                    input logic fin);
        return '{STATUS_OK, slot, h, rts, acq, rel, fin};
    endfunction

    function automatic int first_free(input int start);
        for (int i = start; i < SLOTS; i++)
            if (!tbl_used[i])
                return i;
        return -1;
    endfunction

    function automatic void fill_slot(input int s, input logic [HANDLE_BITS-1:0] h,
                                      input logic [3:0] rts, input bit cx);
        tbl_used[s] = 1'b1;
        tbl_handle[s] = h;
        tbl_rights[s] = rts;
        tbl_cloexec[s] = cx;
    endfunction

    function automatic void clear_slot(input int s);
        tbl_used[s] = 1'b0;
        tbl_handle[s] = '0;
        tbl_rights[s] = '0;
        tbl_cloexec[s] = 1'b0;
    endfunction

    function automatic void apply_request(input req_t item);
        int                     src;
        int                     tgt;
        int                     s;
        bit                     src_ok;
        bit                     displaced;
        bit                     at_min;
        bit                     have;
        logic [3:0]             dflt;
        logic [3:0]             rts;
        logic [HANDLE_BITS-1:0] h;
        logic [HANDLE_BITS-1:0] old_h;
        rsp_t                   held;
        src = int'(item.slot_index);
        tgt = int'(item.target_slot);
        src_ok = (src < SLOTS) ? tbl_used[src] : 1'b0;
        dflt = 4'b1100;
        dflt[0] = (item.access_mode != 2'd1);
        dflt[1] = (item.access_mode != 2'd0);
        at_min = (item.req_type == REQ_DUP_MIN);
        case (item.req_type)
            REQ_ALLOC:
            begin
                rts = (item.rights_arg == 8'd0) ? dflt : (item.rights_arg[3:0] & dflt);
                s = first_free(0);
                if (item.rights_arg[7:4] != 4'd0)
                    due_results.push_back(status_only(STATUS_INVALID));
                else if (rts == 4'd0)
                    due_results.push_back(status_only(STATUS_DENIED));
                else if (s < 0)
                    due_results.push_back(status_only(STATUS_FULL));
                else
                begin
                    fill_slot(s, item.object_handle, rts, item.close_on_exec);
                    due_results.push_back(ok_rsp(8'(s), item.object_handle, rts,
                                                 1'b0, 1'b0, 1'b1));
                end
            end
            REQ_GET:
            begin
                if (src >= SLOTS)
                    due_results.push_back(status_only(STATUS_BAD_SLOT));
                else if (item.rights_arg[7:4] != 4'd0)
                    due_results.push_back(status_only(STATUS_INVALID));
                else if (!tbl_used[src] ||
                         (tbl_rights[src] & item.rights_arg[3:0]) != item.rights_arg[3:0])
                    due_results.push_back(status_only(STATUS_BAD_SLOT));
                else
                    due_results.push_back(ok_rsp(8'(src), tbl_handle[src], tbl_rights[src],
                                                 1'b1, 1'b0, 1'b1));
            end
            REQ_READ:
            begin
                if (!src_ok)
                    due_results.push_back(status_only(STATUS_BAD_SLOT));
                else
                    due_results.push_back(ok_rsp(8'(src), tbl_handle[src], tbl_rights[src],
                                                 1'b0, 1'b0, 1'b1));
            end
            REQ_LIMIT:
            begin
                if (src >= SLOTS)
                    due_results.push_back(status_only(STATUS_BAD_SLOT));
                else if (item.rights_arg[7:4] != 4'd0)
                    due_results.push_back(status_only(STATUS_INVALID));
                else if (!tbl_used[src])
                    due_results.push_back(status_only(STATUS_BAD_SLOT));
                else
                begin
                    tbl_rights[src] = tbl_rights[src] & item.rights_arg[3:0];
                    due_results.push_back(ok_rsp(8'(src), tbl_handle[src], tbl_rights[src],
                                                 1'b0, 1'b0, 1'b1));
                end
            end
            REQ_CLOSE:
            begin
                if (!src_ok)
                    due_results.push_back(status_only(STATUS_BAD_SLOT));
                else
                begin
                    due_results.push_back(ok_rsp(8'(src), tbl_handle[src], 4'd0,
                                                 1'b0, 1'b1, 1'b1));
                    clear_slot(src);
                end
            end
            REQ_DUP, REQ_DUP_MIN:
            begin
                s = first_free(at_min ? tgt : 0);
                if (at_min && tgt >= SLOTS)
                    due_results.push_back(status_only(STATUS_FULL));
                else if (!src_ok)
                    due_results.push_back(status_only(STATUS_BAD_SLOT));
                else if (!tbl_rights[src][RIGHT_DUP_BIT])
                    due_results.push_back(status_only(STATUS_NO_PERM));
                else if (s < 0)
                    due_results.push_back(status_only(STATUS_FULL));
                else
                begin
                    h = tbl_handle[src];
                    rts = tbl_rights[src];
                    fill_slot(s, h, rts, at_min ? item.close_on_exec : 1'b0);
                    due_results.push_back(ok_rsp(8'(s), h, rts, 1'b1, 1'b0, 1'b1));
                end
            end
            REQ_DUP_TO:
            begin
                if (tgt >= SLOTS || !src_ok)
                    due_results.push_back(status_only(STATUS_BAD_SLOT));
                else if (src == tgt)
                    due_results.push_back(ok_rsp(8'(tgt), tbl_handle[tgt], tbl_rights[tgt],
                                                 1'b0, 1'b0, 1'b1));
                else if (!tbl_rights[src][RIGHT_DUP_BIT])
                    due_results.push_back(status_only(STATUS_NO_PERM));
                else
                begin
                    displaced = tbl_used[tgt];
                    old_h = tbl_handle[tgt];
                    h = tbl_handle[src];
                    rts = tbl_rights[src];
                    fill_slot(tgt, h, rts, item.close_on_exec);
                    due_results.push_back(ok_rsp(8'(tgt), h, rts, 1'b1, 1'b0, !displaced));
                    if (displaced)
                        due_results.push_back(ok_rsp(8'(tgt), old_h, rts, 1'b0, 1'b1, 1'b1));
                end
            end
            REQ_SWEEP_CX, REQ_CLOSE_ALL:
            begin
                have = 1'b0;
                held = '0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_used[i] && (item.req_type == REQ_CLOSE_ALL || tbl_cloexec[i]))
                    begin
                        if (have)
                            due_results.push_back(held);
                        held = ok_rsp(8'(i), tbl_handle[i], 4'd0, 1'b0, 1'b1, 1'b0);
                        have = 1'b1;
                        clear_slot(i);
                    end
                end
                if (have)
                begin
                    held.last = 1'b1;
                    due_results.push_back(held);
                end
            end
            default:
                due_results.push_back(status_only(STATUS_INVALID));
        endcase
    endfunction

    function automatic req_t make_req(input logic [3:0] op, input logic [HANDLE_BITS-1:0] h,
                                      input logic [1:0] mode, input logic [7:0] rarg,
                                      input logic [7:0] slot, input logic [7:0] tgt,
                                      input logic cx);
        req_t r;
        r.req_type = req_code_t'(op);
        r.object_handle = h;
        r.access_mode = mode;
        r.rights_arg = rarg;
        r.slot_index = slot;
        r.target_slot = tgt;
        r.close_on_exec = cx;
        return r;
    endfunction

    task automatic add_row(input req_t item, input bit typed, input rsp_t want);
        stim_row_t r;
        r.item = item;
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endtask

    // bias towards used slots, with some out-of-range indexes
    function automatic logic [7:0] pick_slot();
        int k;
        k = $urandom_range(0, SLOTS - 1);
        if ($urandom_range(0, 99) < 15)
            return 8'($urandom_range(0, 255));
        for (int n = 0; n < SLOTS; n++)
            if (tbl_used[(k + n) % SLOTS])
                return 8'((k + n) % SLOTS);
        return 8'(k);
    endfunction

    function automatic req_t random_item(input int kind);
        req_t       r;
        int         p;
        logic [3:0] op;
        p = $urandom_range(0, 99);
        if (kind == KIND_FILL && p < 85)
            op = REQ_ALLOC;
        else if (kind == KIND_DRAIN && p < 40)
            op = REQ_CLOSE;
        else
        begin
            p = $urandom_range(0, 99);
            if (p < 18)
                op = REQ_ALLOC;
            else if (p < 30)
                op = REQ_GET;
            else if (p < 38)
                op = REQ_READ;
            else if (p < 48)
                op = REQ_LIMIT;
            else if (p < 60)
                op = REQ_CLOSE;
            else if (p < 70)
                op = REQ_DUP;
            else if (p < 80)
                op = REQ_DUP_TO;
            else if (p < 90)
                op = REQ_DUP_MIN;
            else if (p < 94)
                op = REQ_SWEEP_CX;
            else if (p < 96)
                op = REQ_CLOSE_ALL;
            else
                op = 4'($urandom_range(10, 15));
        end
        r.req_type = req_code_t'(op);
        r.object_handle = HANDLE_BITS'($urandom);
        r.access_mode = 2'($urandom_range(0, 3));
        p = $urandom_range(0, 99);
        if (p < 15)
            r.rights_arg = 8'd0;
        else if (p < 85)
            r.rights_arg = 8'($urandom_range(0, 15));
        else
            r.rights_arg = 8'($urandom_range(0, 255));
        r.slot_index = pick_slot();
        r.target_slot = $urandom_range(0, 1) ? pick_slot() : 8'($urandom_range(0, SLOTS - 1));
        r.close_on_exec = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic issue(input req_t item, input bit typed, input rsp_t want);
        int gap;
        int n;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_bus <= item;
        do @(posedge clk); while (!req_ready);
        n = due_results.size();
        apply_request(item);
        if (typed)
        begin
            while (due_results.size() > n)
                void'(due_results.pop_back());
            due_results.push_back(want);
        end
    endtask

    // hold the sender until every expected item is back
    task automatic hold_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic string describe(input rsp_t r);
        return $sformatf("status %0d slot %0d handle %h rights %h acq %b rel %b last %b",
                         r.status, r.slot_out, r.handle_out, r.rights_out,
                         r.acquire_ref, r.release_ref, r.last);
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: %s", describe(rsp_bus));
            end
            else
            begin
                want = due_results.pop_front();
                if (want.status !== rsp_bus.status || want.slot_out !== rsp_bus.slot_out ||
                    want.handle_out !== rsp_bus.handle_out ||
                    want.rights_out !== rsp_bus.rights_out ||
                    want.acquire_ref !== rsp_bus.acquire_ref ||
                    want.release_ref !== rsp_bus.release_ref || want.last !== rsp_bus.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %s, got %s", describe(want),
                                 describe(rsp_bus));
                end
            end
        end
    end

    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rsp_t first_alloc;
        int   kind;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_bus = '0;
        for (int i = 0; i < SLOTS; i++)
            clear_slot(i);
        first_alloc = '{STATUS_OK, 8'd0, 16'hFFFF, 4'hF, 1'b0, 1'b0, 1'b1};

        add_row(make_req(REQ_GET, 16'h0, 2'd0, 8'h00, 8'd0, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_BAD_SLOT));
        add_row(make_req(REQ_SWEEP_CX, 16'h0, 2'd0, 8'h00, 8'd0, 8'd0, 1'b0), 1'b0, '0);
        add_row(make_req(REQ_ALLOC, 16'hFFFF, 2'd2, 8'h00, 8'd0, 8'd0, 1'b1), 1'b1,
                first_alloc);
        add_row(make_req(REQ_ALLOC, 16'h0000, 2'd0, 8'h00, 8'd0, 8'd0, 1'b0), 1'b0, '0);
        add_row(make_req(REQ_ALLOC, 16'h5555, 2'd1, 8'hF0, 8'd0, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_INVALID));
        add_row(make_req(REQ_ALLOC, 16'hAAAA, 2'd0, 8'h02, 8'd0, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_DENIED));
        add_row(make_req(REQ_ALLOC, 16'h1234, 2'd3, 8'h0F, 8'd0, 8'd0, 1'b1), 1'b0, '0);
        add_row(make_req(REQ_GET, 16'h0, 2'd0, 8'h00, 8'hFF, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_BAD_SLOT));
        add_row(make_req(REQ_GET, 16'h0, 2'd0, 8'h10, 8'd0, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_INVALID));
        add_row(make_req(REQ_GET, 16'h0, 2'd0, 8'h02, 8'd1, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_BAD_SLOT));
        add_row(make_req(REQ_GET, 16'h0, 2'd0, 8'h0F, 8'd0, 8'd0, 1'b0), 1'b0, '0);
        add_row(make_req(REQ_READ, 16'h0, 2'd0, 8'h00, 8'd63, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_BAD_SLOT));
        add_row(make_req(REQ_LIMIT, 16'h0, 2'd0, 8'h07, 8'd2, 8'd0, 1'b0), 1'b0, '0);
        add_row(make_req(REQ_LIMIT, 16'h0, 2'd0, 8'hFF, 8'd200, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_BAD_SLOT));
        add_row(make_req(REQ_LIMIT, 16'h0, 2'd0, 8'h80, 8'd0, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_INVALID));
        add_row(make_req(REQ_DUP, 16'h0, 2'd0, 8'h00, 8'd2, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_NO_PERM));
        add_row(make_req(REQ_DUP, 16'h0, 2'd0, 8'h00, 8'd0, 8'd0, 1'b1), 1'b0, '0);
        add_row(make_req(REQ_DUP_TO, 16'h0, 2'd0, 8'h00, 8'd0, 8'd0, 1'b0), 1'b0, '0);
        add_row(make_req(REQ_DUP_TO, 16'h0, 2'd0, 8'h00, 8'd0, 8'd1, 1'b0), 1'b0, '0);
        add_row(make_req(REQ_DUP_TO, 16'h0, 2'd0, 8'h00, 8'd0, 8'hFF, 1'b0), 1'b1,
                status_only(STATUS_BAD_SLOT));
        add_row(make_req(REQ_DUP_TO, 16'h0, 2'd0, 8'h00, 8'd2, 8'd5, 1'b0), 1'b1,
                status_only(STATUS_NO_PERM));
        add_row(make_req(REQ_DUP_MIN, 16'h0, 2'd0, 8'h00, 8'd0, 8'd64, 1'b0), 1'b1,
                status_only(STATUS_FULL));
        add_row(make_req(REQ_DUP_MIN, 16'h0, 2'd0, 8'h00, 8'd0, 8'd63, 1'b1), 1'b0, '0);
        add_row(make_req(REQ_CLOSE, 16'h0, 2'd0, 8'h00, 8'd3, 8'd0, 1'b0), 1'b0, '0);
        add_row(make_req(REQ_CLOSE, 16'h0, 2'd0, 8'h00, 8'd3, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_BAD_SLOT));
        add_row(make_req(REQ_UNKNOWN, 16'h0, 2'd0, 8'h00, 8'd0, 8'd0, 1'b0), 1'b1,
                status_only(STATUS_INVALID));
        add_row(make_req(REQ_SWEEP_CX, 16'h0, 2'd0, 8'h00, 8'd0, 8'd0, 1'b0), 1'b0, '0);
        add_row(make_req(REQ_CLOSE_ALL, 16'h0, 2'd0, 8'h00, 8'd0, 8'd0, 1'b0), 1'b0, '0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            issue(rows[i].item, rows[i].typed, rows[i].want);
        hold_until_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_on = (ph % 4 != 3);
            kind = (ph < 3 || ph == 6 || ph == 7) ? KIND_FILL :
                   (ph == 4 || ph == 9) ? KIND_DRAIN : KIND_MIXED;
            repeat (PHASE_ITEMS)
                issue(random_item(kind), 1'b0, '0);
            hold_until_drained();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/dte_pkg.sv
src/dte_ctrl.sv
src/dte_datapath.sv
src/descriptor_table_engine.sv
src/dte_checker.sv
test/descriptor_table_engine_tb.sv
